FILE: rtl/llp_pkg.sv
// Shared types, constants and helpers for the linked list partition block.
package llp_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int LINK_BITS  = ADDR_BITS + 1;
    localparam int STEP_BITS  = ADDR_BITS + 1;
    localparam int CFG_BITS   = 32;

    typedef logic [1:0] t_action;
    localparam t_action ACT_LOAD  = 2'd0;
    localparam t_action ACT_BEGIN = 2'd1;
    localparam t_action ACT_PULL  = 2'd2;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_THRESHOLD = 1'b0;
    localparam t_cfg_index CFG_START     = 1'b1;

    typedef logic [1:0] t_group;
    localparam t_group GRP_NEG  = 2'd0;
    localparam t_group GRP_MID  = 2'd1;
    localparam t_group GRP_HIGH = 2'd2;
    localparam t_group GRP_DONE = 2'd3;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic        [LINK_BITS-1:0]  link;   // top bit set means end of list
    } t_node;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        t_node                wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } t_store_req;

    typedef struct packed {
        logic                         valid;
        logic [ADDR_BITS-1:0]         out_address;
        logic signed [VALUE_BITS-1:0] out_value;
        logic signed [LINK_BITS-1:0]  out_next;
        logic                         is_last;
        logic                         is_empty;
    } t_result;

    function automatic t_group group_of(input logic signed [VALUE_BITS-1:0] value,
                                        input logic signed [VALUE_BITS-1:0] thr);
        t_group g;
        if (value[VALUE_BITS-1]) begin
            g = GRP_NEG;
        end else if (value <= thr) begin
            g = GRP_MID;
        end else begin
            g = GRP_HIGH;
        end
        return g;
    endfunction

endpackage

FILE: rtl/llp_if.sv
// Valid/ready channel interfaces for input and result items.
interface llp_in_if import llp_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [ADDR_BITS-1:0]         node_address;
    logic signed [VALUE_BITS-1:0] node_value;
    logic signed [LINK_BITS-1:0]  next_address;

    modport source (output valid, action, node_address, node_value, next_address,
                    input ready);
    modport sink   (input valid, action, node_address, node_value, next_address,
                    output ready);
endinterface

interface llp_out_if import llp_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic [ADDR_BITS-1:0]         out_address;
    logic signed [VALUE_BITS-1:0] out_value;
    logic signed [LINK_BITS-1:0]  out_next;
    logic                         is_last;
    logic                         is_empty;

    modport source (output valid, out_address, out_value, out_next, is_last, is_empty,
                    input ready);
    modport sink   (input valid, out_address, out_value, out_next, is_last, is_empty,
                    output ready);
endinterface

FILE: rtl/llp_store.sv
// Node store: one write port, one registered read port.
module llp_store import llp_pkg::*; (
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_node      o_rdata
);

    t_node r_mem [2**ADDR_BITS];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/llp_walker.sv
// Traversal sequencer: loads, group passes over the list, one-node lookahead.
module llp_walker import llp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  t_action                      i_action,
    input  logic [ADDR_BITS-1:0]         i_node_address,
    input  logic signed [VALUE_BITS-1:0] i_node_value,
    input  logic signed [LINK_BITS-1:0]  i_next_address,
    input  logic signed [VALUE_BITS-1:0] i_threshold,
    input  logic [ADDR_BITS-1:0]         i_start,
    output logic                         o_ready,
    output t_store_req                   o_req,
    input  t_node                        i_rdata,
    output t_result                      o_res,
    input  logic                         i_res_take
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_PULL_VAL = 5'b00010,
        S_ADV      = 5'b00100,
        S_ADV_CHK  = 5'b01000,
        S_EMIT     = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    t_group                       r_group, n_group;
    logic [ADDR_BITS-1:0]         r_cursor, n_cursor;
    logic                         r_cur_valid, n_cur_valid;
    logic [STEP_BITS-1:0]         r_steps, n_steps;
    logic [ADDR_BITS-1:0]         r_pend_node, n_pend_node;
    logic                         r_pend_valid, n_pend_valid;
    logic                         r_from_pull, n_from_pull;
    logic [ADDR_BITS-1:0]         r_emit_addr, n_emit_addr;
    logic signed [VALUE_BITS-1:0] r_emit_val, n_emit_val;
    logic                         r_emit_empty, n_emit_empty;

    // next cursor position after the node just read
    logic [STEP_BITS-1:0]  chk_steps;
    logic                  chk_cur_valid;
    logic [ADDR_BITS-1:0]  chk_cursor;
    logic                  chk_match;

    assign chk_steps     = r_steps + STEP_BITS'(1);
    assign chk_cur_valid = ~i_rdata.link[LINK_BITS-1];
    assign chk_cursor    = chk_cur_valid ? i_rdata.link[ADDR_BITS-1:0] : r_cursor;
    assign chk_match     = (group_of(i_rdata.value, i_threshold) == r_group);

    always_comb begin
        n_state      = r_state;
        n_group      = r_group;
        n_cursor     = r_cursor;
        n_cur_valid  = r_cur_valid;
        n_steps      = r_steps;
        n_pend_node  = r_pend_node;
        n_pend_valid = r_pend_valid;
        n_from_pull  = r_from_pull;
        n_emit_addr  = r_emit_addr;
        n_emit_val   = r_emit_val;
        n_emit_empty = r_emit_empty;
        o_req        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    unique case (i_action)
                        ACT_LOAD: begin
                            o_req.we          = 1'b1;
                            o_req.waddr       = i_node_address;
                            o_req.wdata.value = i_node_value;
                            o_req.wdata.link  = i_next_address;
                        end
                        ACT_BEGIN: begin
                            n_group      = GRP_NEG;
                            n_cursor     = i_start;
                            n_cur_valid  = 1'b1;
                            n_steps      = '0;
                            n_pend_valid = 1'b0;
                            n_from_pull  = 1'b0;
                            n_state      = S_ADV;
                        end
                        ACT_PULL: begin
                            n_from_pull = 1'b1;
                            if (r_pend_valid) begin
                                o_req.re    = 1'b1;
                                o_req.raddr = r_pend_node;
                                n_state     = S_PULL_VAL;
                            end else begin
                                n_emit_empty = 1'b1;
                                n_state      = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PULL_VAL: begin
                // value is taken now, before the lookahead walks on
                n_emit_addr  = r_pend_node;
                n_emit_val   = i_rdata.value;
                n_emit_empty = 1'b0;
                n_pend_valid = 1'b0;
                n_state      = S_ADV;
            end
            S_ADV: begin
                if (r_group == GRP_DONE) begin
                    n_state = r_from_pull ? S_EMIT : S_IDLE;
                end else if (r_cur_valid && !r_steps[STEP_BITS-1]) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_cursor;
                    n_state     = S_ADV_CHK;
                end else begin
                    n_group = r_group + 2'd1;
                    if (r_group != GRP_HIGH) begin
                        n_cursor    = i_start;
                        n_cur_valid = 1'b1;
                        n_steps     = '0;
                    end
                end
            end
            S_ADV_CHK: begin
                n_steps     = chk_steps;
                n_cur_valid = chk_cur_valid;
                n_cursor    = chk_cursor;
                if (chk_match) begin
                    n_pend_node  = r_cursor;
                    n_pend_valid = 1'b1;
                    n_state      = r_from_pull ? S_EMIT : S_IDLE;
                end else if (chk_cur_valid && !chk_steps[STEP_BITS-1]) begin
                    // keep streaming: one node read per cycle
                    o_req.re    = 1'b1;
                    o_req.raddr = chk_cursor;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_group      <= GRP_NEG;
            r_cursor     <= '0;
            r_cur_valid  <= 1'b0;
            r_steps      <= '0;
            r_pend_node  <= '0;
            r_pend_valid <= 1'b0;
            r_from_pull  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_group      <= n_group;
            r_cursor     <= n_cursor;
            r_cur_valid  <= n_cur_valid;
            r_steps      <= n_steps;
            r_pend_node  <= n_pend_node;
            r_pend_valid <= n_pend_valid;
            r_from_pull  <= n_from_pull;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_addr  <= n_emit_addr;
        r_emit_val   <= n_emit_val;
        r_emit_empty <= n_emit_empty;
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_res       = '0;
        o_res.valid = (r_state == S_EMIT);
        if (r_emit_empty) begin
            o_res.is_empty = 1'b1;
        end else begin
            o_res.out_address = r_emit_addr;
            o_res.out_value   = r_emit_val;
            o_res.out_next    = r_pend_valid ? {1'b0, r_pend_node} : '1;
            o_res.is_last     = ~r_pend_valid;
        end
    end

endmodule

FILE: rtl/linked_list_three_way_partition.sv
// Load writes the node store as it is accepted. Begin restarts the walk at the start address:
// nodes are read in turn, one pass per group, until the first match. Pull reads the pending
// node, walks on to the next match as for begin and hands the result to the output register;
// with nothing pending it gives an empty result. A new item is taken only while idle.
// Reset (synchronous, active low) clears control, config and traversal state;
// the node store is not cleared and entries are undefined until loaded.
module linked_list_three_way_partition import llp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    llp_in_if.sink               i_in,
    llp_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  t_cfg_index           i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_data
);

    logic signed [VALUE_BITS-1:0] r_threshold;
    logic [ADDR_BITS-1:0]         r_start;

    logic                         r_out_valid;
    logic [ADDR_BITS-1:0]         r_out_address;
    logic signed [VALUE_BITS-1:0] r_out_value;
    logic signed [LINK_BITS-1:0]  r_out_next;
    logic                         r_out_last;
    logic                         r_out_empty;

    logic       walk_ready;
    logic       in_accept;
    logic       slot_free;
    t_store_req store_req;
    t_node      store_rdata;
    t_result    walk_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_start     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[VALUE_BITS-1:0];
                CFG_START:     r_start     <= i_cfg_data[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign in_accept  = i_in.valid && walk_ready;
    assign i_in.ready = walk_ready;
    assign slot_free  = !r_out_valid || o_out.ready;

    llp_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    llp_walker u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_action       (i_in.action),
        .i_node_address (i_in.node_address),
        .i_node_value   (i_in.node_value),
        .i_next_address (i_in.next_address),
        .i_threshold    (r_threshold),
        .i_start        (r_start),
        .o_ready        (walk_ready),
        .o_req          (store_req),
        .i_rdata        (store_rdata),
        .o_res          (walk_res),
        .i_res_take     (slot_free)
    );

    // output register: the next item can come in while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= walk_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && walk_res.valid) begin
            r_out_address <= walk_res.out_address;
            r_out_value   <= walk_res.out_value;
            r_out_next    <= walk_res.out_next;
            r_out_last    <= walk_res.is_last;
            r_out_empty   <= walk_res.is_empty;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_address = r_out_address;
    assign o_out.out_value   = r_out_value;
    assign o_out.out_next    = r_out_next;
    assign o_out.is_last     = r_out_last;
    assign o_out.is_empty    = r_out_empty;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_empty |-> o_out.out_address == '0 &&
            o_out.out_value == '0 && o_out.out_next == '0 && !o_out.is_last)
        else $error("empty result carries nonzero fields");

    a_last_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_empty |-> (o_out.is_last == (o_out.out_next == '1)))
        else $error("is_last disagrees with out_next");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.action == ACT_LOAD |=> i_in.ready)
        else $error("load item did not finish in one cycle");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_req.we |-> walk_ready && !store_req.re)
        else $error("store write outside idle or with a read");

endmodule

FILE: tb/sv/partition_order_checker.sv
`timescale 1ns / 1ps
// Checker for the partition block: tracks the node store and traversal, predicts each pull result.
module partition_order_checker import llp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    llp_in_if                   i_in_ch,
    llp_out_if                  i_out_ch,
    input  logic                i_cfg_we,
    input  t_cfg_index          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_waiting
);

    localparam int STORE_DEPTH = 1 << ADDR_BITS;

    typedef struct {
        logic [ADDR_BITS-1:0]         address;
        logic signed [VALUE_BITS-1:0] value;
        logic signed [LINK_BITS-1:0]  successor;
        logic                         at_end;
        logic                         none_left;
    } t_emitted;

    logic signed [VALUE_BITS-1:0] value_mem [STORE_DEPTH];
    logic [LINK_BITS-1:0]         link_mem [STORE_DEPTH];
    logic signed [VALUE_BITS-1:0] threshold_q;
    logic [ADDR_BITS-1:0]         head_q;

    // traversal state: current group pass, walk cursor, one-node lookahead
    t_group               scan_group;
    logic [ADDR_BITS-1:0] cursor;
    bit                   cursor_live;
    int                   pass_count;
    logic [ADDR_BITS-1:0] lookahead;
    bit                   lookahead_ok;

    t_emitted expected_nodes[$];
    int       mismatches;

    function automatic t_group node_group(logic signed [VALUE_BITS-1:0] v);
        if (v < 0) begin
            return GRP_NEG;
        end
        if (v <= threshold_q) begin
            return GRP_MID;
        end
        return GRP_HIGH;
    endfunction

    // walk on to the next node of the current group; a pass stops at the list end
    // or after one visit per store entry, so cycles terminate
    task automatic seek_next_match();
        logic [ADDR_BITS-1:0] a;
        logic [LINK_BITS-1:0] ln;
        lookahead_ok = 1'b0;
        while (scan_group != GRP_DONE) begin
            while (cursor_live && pass_count < STORE_DEPTH) begin
                a = cursor;
                ln = link_mem[a];
                pass_count++;
                if (ln[LINK_BITS-1]) begin
                    cursor_live = 1'b0;
                end else begin
                    cursor = ln[ADDR_BITS-1:0];
                end
                if (node_group(value_mem[a]) == scan_group) begin
                    lookahead = a;
                    lookahead_ok = 1'b1;
                    return;
                end
            end
            scan_group = scan_group + 2'd1;
            if (scan_group != GRP_DONE) begin
                cursor = head_q;
                cursor_live = 1'b1;
                pass_count = 0;
            end
        end
    endtask

    task automatic apply_item(logic [1:0] act, logic [ADDR_BITS-1:0] adr,
                              logic signed [VALUE_BITS-1:0] val,
                              logic signed [LINK_BITS-1:0] nxt);
        logic [ADDR_BITS-1:0]         node;
        logic signed [VALUE_BITS-1:0] node_val;
        t_emitted                     entry;
        case (act)
            ACT_LOAD: begin
                value_mem[adr] = val;
                link_mem[adr] = nxt;
            end
            ACT_BEGIN: begin
                scan_group = GRP_NEG;
                cursor = head_q;
                cursor_live = 1'b1;
                pass_count = 0;
                seek_next_match();
            end
            ACT_PULL: begin
                if (!lookahead_ok) begin
                    entry = '{'0, '0, '0, 1'b0, 1'b1};
                end else begin
                    node = lookahead;
                    node_val = value_mem[node];
                    seek_next_match();
                    entry = '{node, node_val,
                        lookahead_ok ? {1'b0, lookahead} : {LINK_BITS{1'b1}},
                        !lookahead_ok, 1'b0};
                end
                expected_nodes.insert(expected_nodes.size(), entry);
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(string label, logic [VALUE_BITS-1:0] want,
                                 logic [VALUE_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_emitted want;
        if (!i_rst_n) begin
            scan_group = GRP_NEG;
            cursor = '0;
            cursor_live = 1'b0;
            pass_count = 0;
            lookahead = '0;
            lookahead_ok = 1'b0;
            threshold_q = '0;
            head_q = '0;
            expected_nodes.delete();
            mismatches = 0;
        end else begin
            // a result can never belong to an item accepted at the same edge
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_nodes.size() == 0) begin
                    $display("%0t ns: result with no pull waiting, expected none, actual %h",
                             $time, i_out_ch.out_address);
                    mismatches++;
                end else begin
                    want = expected_nodes.pop_front();
                    compare_field("out_address", want.address, i_out_ch.out_address);
                    compare_field("out_value", want.value, i_out_ch.out_value);
                    compare_field("out_next", want.successor, i_out_ch.out_next);
                    compare_field("is_last", want.at_end, i_out_ch.is_last);
                    compare_field("is_empty", want.none_left, i_out_ch.is_empty);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                apply_item(i_in_ch.action, i_in_ch.node_address, i_in_ch.node_value,
                           i_in_ch.next_address);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_THRESHOLD) begin
                    threshold_q = i_cfg_data[VALUE_BITS-1:0];
                end else begin
                    head_q = i_cfg_data[ADDR_BITS-1:0];
                end
            end
        end
        o_waiting <= expected_nodes.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/linked_list_three_way_partition_test.sv
`timescale 1ns / 1ps
// Testbench top for the linked list partition block: clock, reset, stimulus and verdict.
module linked_list_three_way_partition_test;
    import llp_pkg::*;

    localparam t_action ACT_IGNORED   = 2'd3;
    localparam int      HOLD_CYCLES   = 300;
    localparam int      IDLE_LIMIT    = 600000;
    localparam int      ITEM_GOAL     = 1100;
    localparam int      SETTLE_CYCLES = 40;
    localparam int      ROUNDS_PER_THRESHOLD = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    t_cfg_index          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    int                  fail_count;
    int                  waiting;

    llp_in_if  in_ch();
    llp_out_if out_ch();

    linked_list_three_way_partition dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    partition_order_checker order_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    bit                           no_idle;
    bit                           hold_request;
    logic signed [VALUE_BITS-1:0] cur_threshold;
    logic [ADDR_BITS-1:0]         chain[$];   // current list, head first
    int items_sent, loads_sent, begins_sent, pulls_sent, ignored_sent;
    int results_seen, idle_cycles, thresholds_used;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result count, and a watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen <= results_seen + 1;
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(3, 1);
        end
        if (r < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            case ($urandom_range(4))
                0: return 32'sh8000_0000;
                1: return -1;
                2: return 0;
                3: return 1;
                default: return 32'sh7FFF_FFFF;
            endcase
        end
        if (r < 35) begin
            return cur_threshold + int'($urandom_range(4)) - 2;
        end
        if (r < 60) begin
            return int'($urandom_range(200)) - 100;
        end
        return $urandom;
    endfunction

    // any negative link ends the list, not only -1
    function automatic logic signed [LINK_BITS-1:0] pick_end_link();
        if ($urandom_range(1) == 0) begin
            return {LINK_BITS{1'b1}};
        end
        return {1'b1, 16'($urandom)};
    endfunction

    // valid stays high after a handshake; it drops only before a gap or a pause
    task automatic send_item(t_action act, logic [ADDR_BITS-1:0] adr,
                             logic signed [VALUE_BITS-1:0] val,
                             logic signed [LINK_BITS-1:0] nxt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.node_address <= adr;
        in_ch.node_value <= val;
        in_ch.next_address <= nxt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        case (act)
            ACT_LOAD:  loads_sent++;
            ACT_BEGIN: begins_sent++;
            ACT_PULL:  pulls_sent++;
            default:   ignored_sent++;
        endcase
        if (act != ACT_IGNORED) begin
            items_sent++;
        end
    endtask

    // begin, pull and ignored items carry random payload bits
    task automatic issue(t_action act);
        send_item(act, 16'($urandom), 32'($urandom), 17'($urandom));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(t_cfg_index idx, logic [CFG_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // distinct random addresses, loaded tail first so every link points at a loaded node
    task automatic lay_chain(int len);
        logic [ADDR_BITS-1:0] a;
        bit dup;
        int k;
        chain.delete();
        while (chain.size() < len) begin
            a = 16'($urandom);
            dup = 1'b0;
            foreach (chain[j]) begin
                if (chain[j] == a) begin
                    dup = 1'b1;
                end
            end
            if (!dup) begin
                chain.insert(chain.size(), a);
            end
        end
        for (k = len - 1; k >= 0; k--) begin
            send_item(ACT_LOAD, chain[k], pick_value(),
                      (k == len - 1) ? pick_end_link() : {1'b0, chain[k+1]});
        end
    endtask

    task automatic run_round(int len, bit squeeze);
        int pulls, i, r, k;
        logic signed [LINK_BITS-1:0] lnk;
        lay_chain(len);
        settle();
        program_reg(CFG_START, {16'($urandom), chain[0]});
        if (squeeze) begin
            hold_request = 1'b1;
            no_idle = 1'b1;
        end
        // pulls that continue whatever traversal is left over
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(2, 1)) issue(ACT_PULL);
        end
        issue(ACT_BEGIN);
        pulls = len + $urandom_range(2);
        for (i = 0; i < pulls; i++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                // rewrite a node mid-walk; links only point further down, no cycles
                k = $urandom_range(chain.size() - 1);
                if (k < chain.size() - 1 && $urandom_range(1) == 1) begin
                    lnk = {1'b0, chain[$urandom_range(chain.size() - 1, k + 1)]};
                end else begin
                    lnk = pick_end_link();
                end
                send_item(ACT_LOAD, chain[k], pick_value(), lnk);
            end else if (r < 13) begin
                issue(ACT_IGNORED);
            end else if (r < 16) begin
                issue(ACT_BEGIN);
            end
            issue(ACT_PULL);
        end
    endtask

    task automatic directed_part();
        // pull before any begin
        issue(ACT_PULL);
        // five nodes at value and address extremes, end link negative but not -1
        send_item(ACT_LOAD, 16'h1234, 1, 17'h1_8000);
        send_item(ACT_LOAD, 16'h7FFE, -1, 17'h0_1234);
        send_item(ACT_LOAD, 16'h8001, 0, 17'h0_7FFE);
        send_item(ACT_LOAD, 16'hFFFF, 32'sh7FFF_FFFF, 17'h0_8001);
        send_item(ACT_LOAD, 16'h0000, 32'sh8000_0000, 17'h0_FFFF);
        // threshold and start address still at reset values
        issue(ACT_BEGIN);
        issue(ACT_PULL);
        issue(ACT_PULL);
        // move a node into the negative group after its pass is over
        send_item(ACT_LOAD, 16'h1234, -5, 17'h1_8000);
        repeat (3) issue(ACT_PULL);
        issue(ACT_IGNORED);
        // self loop: the negative pass runs out its step budget
        send_item(ACT_LOAD, 16'h00FF, 0, 17'h0_00FF);
        settle();
        program_reg(CFG_START, 32'h0000_00FF);
        issue(ACT_BEGIN);
        repeat (2) issue(ACT_PULL);
        // two node cycle entered at the top address, nodes emitted repeatedly
        send_item(ACT_LOAD, 16'h0555, 9, 17'h0_00FF);
        send_item(ACT_LOAD, 16'hFFFF, -3, 17'h0_0555);
        send_item(ACT_LOAD, 16'h0555, 9, 17'h0_FFFF);
        settle();
        program_reg(CFG_START, 32'hFFFF_FFFF);
        issue(ACT_BEGIN);
        repeat (4) issue(ACT_PULL);
    endtask

    // output side: ready bursts and stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                int gap;
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(no_idle ? 60 : 8, 1)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int round, len, r;
        logic signed [VALUE_BITS-1:0] thr;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_LOAD;
        in_ch.node_address <= '0;
        in_ch.node_value <= '0;
        in_ch.next_address <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= '0;
        hold_request = 1'b0;
        no_idle = 1'b0;
        cur_threshold = '0;
        round = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();

        while (items_sent < ITEM_GOAL) begin
            if (round % ROUNDS_PER_THRESHOLD == 0) begin
                case ((round / ROUNDS_PER_THRESHOLD) % 6)
                    0: thr = 32'sh8000_0000;
                    1: thr = 32'sh7FFF_FFFF;
                    2: thr = -1;
                    3: thr = $urandom;
                    4: thr = $urandom_range(60);
                    default: thr = 0;
                endcase
                settle();
                program_reg(CFG_THRESHOLD, thr);
                cur_threshold = thr;
                thresholds_used++;
            end
            no_idle = (round % 7 == 3);
            r = $urandom_range(99);
            if (round % 25 == 5) begin
                len = 24;
            end else if (r < 85) begin
                len = $urandom_range(6, 1);
            end else if (r < 97) begin
                len = $urandom_range(12, 7);
            end else begin
                len = 30;
            end
            run_round(len, round % 25 == 5);
            round++;
        end
        settle();

        $display("Ran %0d items: %0d loads, %0d begins, %0d pulls, %0d ignored; %0d results checked",
                 items_sent, loads_sent, begins_sent, pulls_sent, ignored_sent, results_seen);
        $display("Lists of 1 to 30 nodes under %0d threshold settings, plus cyclic lists and a stall",
                 thresholds_used + 1);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
